>>> rtl/core/kcs_pkg.sv
// ----------------------------------------------------------------------------
// kcs_pkg
// shared types and constants of the keyframe curve sampler
// ----------------------------------------------------------------------------
`default_nettype none

package kcs_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int VAL_W            = 32;
    localparam int KIDX_W           = 6;
    localparam int DEFAULT_MAX_KEYS = 64;

    // datapath widths: spline terms, multiplier operand b, product, accumulator
    localparam int H_W     = 40;
    localparam int MB_W    = 18;
    localparam int PROD_W  = H_W + MB_W;
    localparam int ACC_W   = 72;
    localparam int ALPHA_W = FRAC_BITS + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // serial divider widths
    localparam int DIV_R_W   = 34;
    localparam int DIV_D_W   = 32;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD   = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_ALPHA = DIV_CNT_W'(FRAC_BITS);

    typedef struct packed {
        logic                    func;
        logic [KIDX_W-1:0]       key_index;
        logic signed [VAL_W-1:0] time_req;
        logic signed [VAL_W-1:0] value_x;
        logic signed [VAL_W-1:0] value_y;
        logic signed [VAL_W-1:0] value_z;
        logic                    smooth;
        logic signed [VAL_W-1:0] scale;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_x;
        logic signed [VAL_W-1:0] out_y;
        logic signed [VAL_W-1:0] out_z;
    } t_out_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] key_time;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
        logic                    smooth;
    } t_key;

    typedef struct packed {
        logic                 start;
        logic [DIV_R_W-1:0]   r0;
        logic [DIV_D_W-1:0]   dvd;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_D_W-1:0] q;
        logic [DIV_R_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/core/kcs_key_mem.sv
// ----------------------------------------------------------------------------
// kcs_key_mem
// keyframe store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_key_mem #(
    parameter int DEPTH = kcs_pkg::DEFAULT_MAX_KEYS,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire kcs_pkg::t_key i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output kcs_pkg::t_key      o_rdata
);

    kcs_pkg::t_key r_mem [DEPTH];
    kcs_pkg::t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/kcs_div.sv
// ----------------------------------------------------------------------------
// kcs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kcs_pkg::t_div_req i_req,
    output kcs_pkg::t_div_rsp      o_rsp
);

    logic                          r_busy, r_done;
    logic [kcs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [kcs_pkg::DIV_R_W-1:0]   r_rem, w_shift;
    logic [kcs_pkg::DIV_D_W-1:0]   r_dvd, r_q;
    logic [kcs_pkg::DIV_DEN_W-1:0] r_den;
    logic                          w_ge;

    // remainder stays below the divisor, so the shifted value fits
    assign w_shift = {r_rem[kcs_pkg::DIV_R_W-2:0], r_dvd[kcs_pkg::DIV_D_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == kcs_pkg::DIV_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == kcs_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.r0;
            r_dvd <= i_req.dvd;
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_shift - {1'b0, r_den} : w_shift;
            r_dvd <= r_dvd << 1;
            r_q   <= {r_q[kcs_pkg::DIV_D_W-2:0], w_ge};
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, q: r_q, rem: r_rem};

endmodule

`default_nettype wire

>>> rtl/core/keyframe_curve_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_curve_sampler
// keyframe store with Catmull-Rom / linear sampling, scaled and saturated
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid / o_in_stall / i_in_data) carries
// write transactions (func 0), which store one keyframe, and sample
// transactions (func 1), which return one transaction on the output channel
// (o_out_valid / i_out_stall / o_out_data). Writes are stored on accept and
// give no result. Configuration must be written on i_cfg_* only while the
// block is idle; the block itself does not enforce this. A sample passes
// through the time wrap on the serial divider when looping, the search,
// which walks the keys one by one through the registered read port of the
// key memory, the key reads, the alpha set-up, alpha on the divider when the
// time lies strictly between two keys, and the three components on the
// shared multiplier, linear or spline. One transaction is in work at a time;
// o_in_stall is high from accept until the result is taken.
// Reset (synchronous, active low) clears looping, length and sets the key
// count to one; key memory contents are undefined until written. A stalled
// result is held on o_out_data until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_curve_sampler #(
    parameter int MAX_KEYS = kcs_pkg::DEFAULT_MAX_KEYS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire kcs_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output kcs_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [kcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [kcs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int HW = kcs_pkg::H_W;
    localparam int FB = kcs_pkg::FRAC_BITS;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_WRAP  = 10'b0000000010,
        ST_SRCH  = 10'b0000000100,
        ST_FETCH = 10'b0000001000,
        ST_ALPH  = 10'b0000010000,
        ST_DIVA  = 10'b0000100000,
        ST_CPREP = 10'b0001000000,
        ST_MUL   = 10'b0010000000,
        ST_ACC   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    localparam logic [2:0] STP_C2 = 3'd0;
    localparam logic [2:0] STP_C1 = 3'd1;
    localparam logic [2:0] STP_C0 = 3'd2;
    localparam logic [2:0] STP_LO = 3'd3;
    localparam logic [2:0] STP_HI = 3'd4;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    localparam logic [2:0] FET_PREV = 3'd0;
    localparam logic [2:0] FET_NEXT = 3'd1;
    localparam logic [2:0] FET_I0   = 3'd2;
    localparam logic [2:0] FET_I3   = 3'd3;
    localparam logic [2:0] FET_LAST = 3'd4;

    t_state r_state, n_state;

    // configuration
    logic                          r_looping;
    logic [kcs_pkg::CFG_DATA_W-1:0] r_anim_len;
    logic [6:0]                    r_key_count;
    logic [NW-1:0]                 w_n;

    // sample context
    logic signed [31:0]            r_t, n_t;
    logic signed [31:0]            r_scale;
    logic [NW-1:0]                 r_idx, n_idx, r_prev, n_prev, r_next, n_next;
    logic [NW-1:0]                 w_i0, w_i3, w_p;
    logic [2:0]                    r_fcnt, n_fcnt;
    kcs_pkg::t_key                 r_ka, r_kb, r_k0, r_k3;
    logic [kcs_pkg::ALPHA_W-1:0]   r_alpha, n_alpha;
    logic                          r_tneg;

    // arithmetic
    logic [1:0]                    r_comp, n_comp;
    logic [2:0]                    r_step, n_step;
    logic signed [HW-1:0]          r_h, n_h, r_c2, r_c1, r_c0;
    logic signed [HW-1:0]          w_p0, w_p1, w_p2, w_p3, w_fs, w_hn;
    logic signed [kcs_pkg::MB_W-1:0]   w_mb;
    logic signed [kcs_pkg::PROD_W-1:0] r_prod;
    logic signed [kcs_pkg::ACC_W-1:0]  r_acc, w_tot, w_sh;
    logic signed [31:0]            w_sat;
    kcs_pkg::t_out_item            r_out;

    // key memory and divider
    logic                          w_we;
    logic [AW-1:0]                 w_raddr;
    kcs_pkg::t_key                 w_wkey, w_rkey;
    kcs_pkg::t_div_req             w_div_req;
    kcs_pkg::t_div_rsp             w_div_rsp;

    logic                          w_acc_in;
    logic signed [33:0]            w_num, w_den;
    logic [31:0]                   w_tabs, w_rem;

    assign w_acc_in = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_key_count == 7'd0) begin
            w_n = NW'(1);
        end else if (int'(r_key_count) > MAX_KEYS) begin
            w_n = NW'(MAX_KEYS);
        end else begin
            w_n = NW'(r_key_count);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_looping   <= 1'b0;
            r_anim_len  <= '0;
            r_key_count <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kcs_pkg::CFG_LOOPING:   r_looping   <= i_cfg_wdata[0];
                kcs_pkg::CFG_ANIM_LEN:  r_anim_len  <= i_cfg_wdata;
                kcs_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign w_we = w_acc_in && (r_state == ST_IDLE) && (i_in_data.func == kcs_pkg::FUNC_WRITE)
                  && (int'(i_in_data.key_index) < MAX_KEYS);
    assign w_wkey = '{key_time: i_in_data.time_req, x: i_in_data.value_x,
                      y: i_in_data.value_y, z: i_in_data.value_z,
                      smooth: i_in_data.smooth};

    kcs_key_mem #(
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in_data.key_index)),
        .i_wdata (w_wkey),
        .i_raddr (w_raddr),
        .o_rdata (w_rkey)
    );

    kcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // neighbor indices clamped at the ends
    assign w_i0 = (r_prev != '0) ? r_prev - 1'b1 : '0;
    assign w_i3 = (r_next + 1'b1 < w_n) ? r_next + 1'b1 : w_n - 1'b1;
    assign w_p  = (w_rkey.key_time <= r_t) ? r_idx : r_prev;

    assign w_tabs = i_in_data.time_req[31] ? 32'(-i_in_data.time_req)
                                            : 32'(i_in_data.time_req);
    assign w_rem  = w_div_rsp.rem[31:0];
    assign w_num  = 34'(r_t) - 34'(r_ka.key_time);
    assign w_den  = 34'(r_kb.key_time) - 34'(r_ka.key_time);

    // component select and spline coefficients
    always_comb begin
        unique case (r_comp)
            COMP_X: begin
                w_p0 = HW'(r_k0.x); w_p1 = HW'(r_ka.x);
                w_p2 = HW'(r_kb.x); w_p3 = HW'(r_k3.x);
            end
            COMP_Y: begin
                w_p0 = HW'(r_k0.y); w_p1 = HW'(r_ka.y);
                w_p2 = HW'(r_kb.y); w_p3 = HW'(r_k3.y);
            end
            default: begin
                w_p0 = HW'(r_k0.z); w_p1 = HW'(r_ka.z);
                w_p2 = HW'(r_kb.z); w_p3 = HW'(r_k3.z);
            end
        endcase
    end

    always_comb begin
        unique case (r_step)
            STP_LO:  w_mb = {2'b00, r_scale[15:0]};
            STP_HI:  w_mb = {{2{r_scale[31]}}, r_scale[31:16]};
            default: w_mb = {1'b0, r_alpha};
        endcase
    end

    assign w_fs  = HW'(r_prod >>> FB);
    assign w_tot = r_acc + (kcs_pkg::ACC_W'(r_prod) <<< 16);
    assign w_sh  = w_tot >>> FB;

    always_comb begin
        if (w_sh > kcs_pkg::ACC_W'(32'sh7fffffff)) begin
            w_sat = 32'sh7fffffff;
        end else if (w_sh < kcs_pkg::ACC_W'(-33'sh80000000)) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_sh[31:0];
        end
    end

    always_comb begin
        unique case (r_step)
            STP_C2:  w_hn = w_fs + r_c2;
            STP_C1:  w_hn = w_fs + r_c1;
            default: w_hn = w_fs + r_c0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_t       = r_t;
        n_idx     = r_idx;
        n_prev    = r_prev;
        n_next    = r_next;
        n_fcnt    = r_fcnt;
        n_alpha   = r_alpha;
        n_comp    = r_comp;
        n_step    = r_step;
        n_h       = r_h;
        w_raddr   = '0;
        w_div_req = '{start: 1'b0, r0: '0, dvd: '0, den: '0, steps: '0};
        unique case (r_state)
            ST_IDLE: begin
                n_t = i_in_data.time_req;
                if (w_acc_in && (i_in_data.func == kcs_pkg::FUNC_SAMPLE)) begin
                    n_prev = '0;
                    n_fcnt = FET_PREV;
                    if (r_looping && (r_anim_len != '0)) begin
                        w_div_req = '{start: 1'b1, r0: '0, dvd: w_tabs,
                                      den: {2'b00, r_anim_len},
                                      steps: kcs_pkg::DIV_STEPS_MOD};
                        n_state = ST_WRAP;
                    end else if (w_n > NW'(1)) begin
                        w_raddr = AW'(1);
                        n_idx   = NW'(1);
                        n_state = ST_SRCH;
                    end else begin
                        n_next  = '0;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_WRAP: begin
                if (w_div_rsp.done) begin
                    n_t = (r_tneg && (w_rem != '0)) ? 32'({1'b0, r_anim_len} - w_rem)
                                                    : 32'(w_rem);
                    if (w_n > NW'(1)) begin
                        w_raddr = AW'(1);
                        n_idx   = NW'(1);
                        n_state = ST_SRCH;
                    end else begin
                        n_next  = '0;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_SRCH: begin
                // read data holds key r_idx
                if ((w_rkey.key_time <= r_t) && (r_idx + 1'b1 < w_n)) begin
                    n_prev  = r_idx;
                    n_idx   = r_idx + 1'b1;
                    w_raddr = n_idx[AW-1:0];
                end else begin
                    n_prev  = w_p;
                    n_next  = (w_p + 1'b1 < w_n) ? w_p + 1'b1 : w_n - 1'b1;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                unique case (r_fcnt)
                    FET_PREV: w_raddr = r_prev[AW-1:0];
                    FET_NEXT: w_raddr = r_next[AW-1:0];
                    FET_I0:   w_raddr = w_i0[AW-1:0];
                    FET_I3:   w_raddr = w_i3[AW-1:0];
                    default:  w_raddr = '0;
                endcase
                n_fcnt = r_fcnt + 1'b1;
                if (r_fcnt == FET_LAST) begin
                    n_state = ST_ALPH;
                end
            end
            ST_ALPH: begin
                n_comp = COMP_X;
                if ((r_next == r_prev) || (r_kb.key_time <= r_ka.key_time) || (w_num <= 0)) begin
                    n_alpha = '0;
                    n_state = ST_CPREP;
                end else if (w_num >= w_den) begin
                    n_alpha = kcs_pkg::ALPHA_ONE;
                    n_state = ST_CPREP;
                end else begin
                    w_div_req = '{start: 1'b1, r0: w_num, dvd: '0, den: w_den[32:0],
                                  steps: kcs_pkg::DIV_STEPS_ALPHA};
                    n_state = ST_DIVA;
                end
            end
            ST_DIVA: begin
                if (w_div_rsp.done) begin
                    n_alpha = kcs_pkg::ALPHA_W'(w_div_rsp.q[FB-1:0]);
                    n_state = ST_CPREP;
                end
            end
            ST_CPREP: begin
                if (r_kb.smooth) begin
                    n_h    = 3 * w_p1 - w_p0 - 3 * w_p2 + w_p3;
                    n_step = STP_C2;
                end else begin
                    n_h    = w_p2 - w_p1;
                    n_step = STP_C0;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_step  = r_step + 1'b1;
                n_state = ST_MUL;
                unique case (r_step)
                    STP_C2, STP_C1: n_h = w_hn;
                    STP_C0:         n_h = r_kb.smooth ? (w_hn >>> 1) : w_hn;
                    STP_LO:         n_h = r_h;
                    default: begin
                        if (r_comp == COMP_Z) begin
                            n_state = ST_OUT;
                        end else begin
                            n_comp  = r_comp + 1'b1;
                            n_state = ST_CPREP;
                        end
                    end
                endcase
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fcnt  <= FET_PREV;
            r_comp  <= COMP_X;
            r_step  <= STP_C2;
        end else begin
            r_state <= n_state;
            r_fcnt  <= n_fcnt;
            r_comp  <= n_comp;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_next  <= n_next;
        r_alpha <= n_alpha;
        r_h     <= n_h;
        if (r_state == ST_IDLE) begin
            r_scale <= i_in_data.scale;
            r_tneg  <= i_in_data.time_req[31];
        end
        if (r_state == ST_FETCH) begin
            unique case (r_fcnt)
                FET_NEXT: r_ka <= w_rkey;
                FET_I0:   r_kb <= w_rkey;
                FET_I3:   r_k0 <= w_rkey;
                FET_LAST: r_k3 <= w_rkey;
                default: ;
            endcase
        end
        if (r_state == ST_CPREP) begin
            r_c2 <= 2 * w_p0 - 5 * w_p1 + 4 * w_p2 - w_p3;
            r_c1 <= w_p2 - w_p0;
            r_c0 <= r_kb.smooth ? 2 * w_p1 : w_p1;
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_h * w_mb;
        end
        if ((r_state == ST_ACC) && (r_step == STP_LO)) begin
            r_acc <= kcs_pkg::ACC_W'(r_prod);
        end
        if ((r_state == ST_ACC) && (r_step == STP_HI)) begin
            unique case (r_comp)
                COMP_X:  r_out.out_x <= w_sat;
                COMP_Y:  r_out.out_y <= w_sat;
                default: r_out.out_z <= w_sat;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data  = r_out;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result shown while input open");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (r_idx < w_n) && (r_prev < r_idx))
        else $error("search index out of range");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_alpha <= kcs_pkg::ALPHA_ONE))
        else $error("alpha above one");

endmodule

`default_nettype wire
